FILE: hw/rtl/dnd_pkg.sv
`timescale 1ns / 1ps

package dnd_pkg;

	// Message buffer geometry.
	localparam int BUF_DEPTH = 512;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

	// Pointer loop guard.
	localparam int MAX_JUMPS = 16;
	localparam int JMP_W     = $clog2(MAX_JUMPS + 1);

	// Decoded name buffer geometry.
	localparam int NAME_DEPTH = 256;
	localparam int NAME_AW    = $clog2(NAME_DEPTH);

	// Field widths.
	localparam int POS_W   = 14;
	localparam int CHUNK_N = 8;

	// Function codes of an input item.
	localparam logic [1:0] FN_APPEND  = 2'd0;
	localparam logic [1:0] FN_DECODE  = 2'd1;
	localparam logic [1:0] FN_NEW_MSG = 2'd2;

	// Wire format constants.
	localparam logic [1:0] PTR_MARK = 2'b11;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PAST_END = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_JUMPS    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		W_IDLE,
		W_CHECK,
		W_LEN,
		W_PTR,
		W_COPY,
		W_DONE
	} walk_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_FILL,
		E_OUT
	} emit_state_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       data_byte;
		logic [POS_W-1:0] name_offset;
	} in_item_t;

	typedef struct packed {
		logic [63:0] name_chars;
		logic [3:0]  char_count;
		logic        last;
		status_t     status;
	} out_item_t;

	// Handoff from the label walker to the chunk emitter.
	typedef struct packed {
		logic               start;
		status_t            status;
		logic [NAME_AW-1:0] name_len;
	} walk_done_t;

endpackage

FILE: hw/rtl/dnd_ram.sv
`timescale 1ns / 1ps

module dnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/dnd_walk.sv
`timescale 1ns / 1ps

module dnd_walk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  dnd_pkg::in_item_t           in_data,
	input  logic [7:0]                  name_limit,
	input  logic                        emit_busy,
	output logic                        msg_we,
	output logic [dnd_pkg::BUF_AW-1:0]  msg_waddr,
	output logic [7:0]                  msg_wdata,
	output logic [dnd_pkg::BUF_AW-1:0]  msg_raddr,
	input  logic [7:0]                  msg_rdata,
	output logic                        name_we,
	output logic [dnd_pkg::NAME_AW-1:0] name_waddr,
	output logic [7:0]                  name_wdata,
	output dnd_pkg::walk_done_t         done
);

	import dnd_pkg::*;

	walk_state_t        state_q, state_d;
	logic [POS_W-1:0]   rp_q, rp_d;
	logic [LEN_W-1:0]   ml_q, ml_d;
	logic [JMP_W-1:0]   jc_q, jc_d;
	logic [NAME_AW-1:0] nl_q, nl_d;
	logic [7:0]         len_q, len_d;
	logic [7:0]         cnt_q, cnt_d;
	status_t            status_q, status_d;

	logic [POS_W:0]     pos_ext;
	logic [POS_W:0]     ml_ext;
	logic [POS_W:0]     label_end;
	logic [POS_W:0]     ptr_end;
	logic [9:0]         grown;
	logic [POS_W-1:0]   rp_inc;
	logic               in_acc;

	// Bounds and length arithmetic on the byte just read.
	assign pos_ext   = {1'b0, rp_q};
	assign ml_ext    = (POS_W + 1)'(ml_q);
	assign label_end = pos_ext + (POS_W + 1)'(msg_rdata) + (POS_W + 1)'(1);
	assign ptr_end   = pos_ext + (POS_W + 1)'(2);
	assign grown     = 10'(nl_q) + 10'(msg_rdata) + 10'(nl_q != '0);
	assign rp_inc    = rp_q + POS_W'(1);
	assign in_acc    = in_valid && !in_stall;

	// State register and walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= W_IDLE;
			ml_q     <= '0;
			rp_q     <= '0;
			jc_q     <= '0;
			nl_q     <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			ml_q     <= ml_d;
			rp_q     <= rp_d;
			jc_q     <= jc_d;
			nl_q     <= nl_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		cnt_q <= cnt_d;
	end

	// Next state, memory accesses and handoff.
	always_comb begin
		state_d    = state_q;
		rp_d       = rp_q;
		ml_d       = ml_q;
		jc_d       = jc_q;
		nl_d       = nl_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		status_d   = status_q;
		msg_we     = 1'b0;
		msg_waddr  = ml_q[BUF_AW-1:0];
		msg_wdata  = in_data.data_byte;
		msg_raddr  = rp_q[BUF_AW-1:0];
		name_we    = 1'b0;
		name_waddr = nl_q;
		name_wdata = msg_rdata;
		done       = '0;
		// A new decode waits until the previous name has been sent out.
		in_stall   = (state_q != W_IDLE) || (emit_busy && in_data.func == FN_DECODE);

		unique case (state_q)
			W_IDLE: begin
				if (in_acc) begin
					case (in_data.func)
						FN_APPEND: begin
							if (ml_q < LEN_W'(BUF_DEPTH)) begin
								msg_we = 1'b1;
								ml_d   = ml_q + LEN_W'(1);
							end
						end
						FN_DECODE: begin
							rp_d    = in_data.name_offset;
							jc_d    = '0;
							nl_d    = '0;
							state_d = W_CHECK;
						end
						FN_NEW_MSG: begin
							ml_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			W_CHECK: begin
				// Reading at or past the end closes the name normally.
				if (pos_ext >= ml_ext) begin
					status_d = ST_OK;
					state_d  = W_DONE;
				end else begin
					state_d = W_LEN;
				end
			end
			W_LEN: begin
				len_d = msg_rdata;
				if (msg_rdata == 8'd0) begin
					status_d = ST_OK;
					state_d  = W_DONE;
				end else if (msg_rdata[7:6] == PTR_MARK) begin
					if (ptr_end > ml_ext) begin
						status_d = ST_PAST_END;
						state_d  = W_DONE;
					end else if (jc_q >= JMP_W'(MAX_JUMPS)) begin
						status_d = ST_JUMPS;
						state_d  = W_DONE;
					end else begin
						jc_d      = jc_q + JMP_W'(1);
						msg_raddr = rp_inc[BUF_AW-1:0];
						state_d   = W_PTR;
					end
				end else if (label_end > ml_ext) begin
					status_d = ST_PAST_END;
					state_d  = W_DONE;
				end else if (grown >= 10'(name_limit)) begin
					status_d = ST_TOO_LONG;
					state_d  = W_DONE;
				end else begin
					// Join with a dot, then start streaming the label bytes.
					if (nl_q != '0) begin
						name_we    = 1'b1;
						name_wdata = DOT_CHAR;
						nl_d       = nl_q + NAME_AW'(1);
					end
					msg_raddr = rp_inc[BUF_AW-1:0];
					rp_d      = rp_q + POS_W'(2);
					cnt_d     = msg_rdata - 8'd1;
					state_d   = W_COPY;
				end
			end
			W_PTR: begin
				rp_d    = {len_q[5:0], msg_rdata};
				state_d = W_CHECK;
			end
			W_COPY: begin
				// One label byte arrives and one more is requested each cycle.
				name_we = 1'b1;
				nl_d    = nl_q + NAME_AW'(1);
				if (cnt_q != 8'd0) begin
					rp_d  = rp_inc;
					cnt_d = cnt_q - 8'd1;
				end else begin
					state_d = W_CHECK;
				end
			end
			W_DONE: begin
				done.start    = 1'b1;
				done.status   = status_q;
				done.name_len = nl_q;
				state_d       = W_IDLE;
			end
			default: begin
				state_d = W_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/dnd_emit.sv
`timescale 1ns / 1ps

module dnd_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dnd_pkg::walk_done_t         done,
	output logic [dnd_pkg::NAME_AW-1:0] name_raddr,
	input  logic [7:0]                  name_rdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output dnd_pkg::out_item_t          out_data,
	output logic                        busy
);

	import dnd_pkg::*;

	emit_state_t        state_q, state_d;
	logic [NAME_AW-1:0] len_q, len_d;
	logic [NAME_AW-1:0] idx_q, idx_d;
	logic [3:0]         iss_q, iss_d;
	logic [3:0]         got_q, got_d;
	logic               pend_q, pend_d;
	logic [63:0]        word_q, word_d;
	logic               last_q, last_d;
	status_t            status_q, status_d;
	logic               issue;

	// A read goes out while the chunk has room and the name has bytes left.
	assign issue = (state_q == E_FILL) && (iss_q != 4'(CHUNK_N)) && (idx_q != len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q    <= len_d;
		idx_q    <= idx_d;
		iss_q    <= iss_d;
		got_q    <= got_d;
		word_q   <= word_d;
		last_q   <= last_d;
		status_q <= status_d;
	end

	// Chunk assembly and output handshake.
	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		idx_d      = idx_q;
		iss_d      = iss_q;
		got_d      = got_q;
		pend_d     = 1'b0;
		word_d     = word_q;
		last_d     = last_q;
		status_d   = status_q;
		name_raddr = idx_q;

		unique case (state_q)
			E_IDLE: begin
				if (done.start) begin
					status_d = done.status;
					len_d    = done.name_len;
					idx_d    = '0;
					iss_d    = '0;
					got_d    = '0;
					word_d   = '0;
					last_d   = 1'b1;
					// Errors and the empty name give one blank final item.
					if (done.status != ST_OK || done.name_len == '0) begin
						state_d = E_OUT;
					end else begin
						state_d = E_FILL;
					end
				end
			end
			E_FILL: begin
				if (issue) begin
					idx_d = idx_q + NAME_AW'(1);
					iss_d = iss_q + 4'd1;
				end
				pend_d = issue;
				if (pend_q) begin
					word_d[got_q[2:0]*8 +: 8] = name_rdata;
					got_d                     = got_q + 4'd1;
				end
				if (!pend_q && !issue) begin
					last_d  = (idx_q == len_q);
					state_d = E_OUT;
				end
			end
			E_OUT: begin
				if (!out_stall) begin
					if (last_q) begin
						state_d = E_IDLE;
					end else begin
						iss_d   = '0;
						got_d   = '0;
						word_d  = '0;
						state_d = E_FILL;
					end
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	assign out_valid           = (state_q == E_OUT);
	assign out_data.name_chars = word_q;
	assign out_data.char_count = got_q;
	assign out_data.last       = last_q;
	assign out_data.status     = status_q;
	assign busy                = (state_q != E_IDLE);

endmodule

FILE: hw/rtl/dns_name_decompressor.sv
`timescale 1ns / 1ps

// Channel  Handshake         Payload     Use
// in       in_valid/stall    in_item_t   append byte, decode name, new message
// out      out_valid/stall   out_item_t  name text in chunks of eight, last marked
// cfg      cfg_valid/ready   8 bits      name_limit, always ready
//
// Append and new-message items are handled without leaving the walker's idle state.
// A decode passes a check and a length-byte state per label or pointer, a pointer
// state per pointer and a copy state per label character, reading the message
// memory through its registered read port; then the emitter fills each chunk from
// the name memory, drains the registered read and offers the chunk until the receiver takes it.
// Reset clears the message and name lengths and control only; the memories are not cleared.
// Every item stalls while a decode walks the labels, and a new decode also
// stalls until the last chunk of the previous one is taken.

module dns_name_decompressor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dnd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output dnd_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	import dnd_pkg::*;

	logic [7:0]         limit_q;
	logic               msg_we;
	logic [BUF_AW-1:0]  msg_waddr;
	logic [7:0]         msg_wdata;
	logic [BUF_AW-1:0]  msg_raddr;
	logic [7:0]         msg_rdata;
	logic               name_we;
	logic [NAME_AW-1:0] name_waddr;
	logic [7:0]         name_wdata;
	logic [NAME_AW-1:0] name_raddr;
	logic [7:0]         name_rdata;
	logic               emit_busy;
	walk_done_t         done;

	// Name length limit register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	dnd_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (msg_waddr),
		.wdata (msg_wdata),
		.raddr (msg_raddr),
		.rdata (msg_rdata)
	);

	dnd_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_waddr),
		.wdata (name_wdata),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	dnd_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.name_limit (limit_q),
		.emit_busy  (emit_busy),
		.msg_we     (msg_we),
		.msg_waddr  (msg_waddr),
		.msg_wdata  (msg_wdata),
		.msg_raddr  (msg_raddr),
		.msg_rdata  (msg_rdata),
		.name_we    (name_we),
		.name_waddr (name_waddr),
		.name_wdata (name_wdata),
		.done       (done)
	);

	dnd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.done       (done),
		.name_raddr (name_raddr),
		.name_rdata (name_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.busy       (emit_busy)
	);

	// The name memory is never rewritten while its chunks are being sent.
	a_name_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		name_we |-> !emit_busy)
		else $error("name memory written while emitter busy");

	// A handoff only reaches an idle emitter.
	a_handoff_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done.start |-> !emit_busy)
		else $error("walk finished while emitter busy");

	// An error item is blank and final.
	a_error_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |->
			(out_data.last && out_data.char_count == 4'd0 && out_data.name_chars == 64'd0))
		else $error("error item carries text");

	// A chunk never claims more than eight characters.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.char_count <= 4'(CHUNK_N)))
		else $error("chunk count out of range");

endmodule
